/* rtl/core/fair_share_task_scheduler_unit_macros.svh */
// Assertion helpers shared by the scheduler RTL.
`ifndef FAIR_SHARE_TASK_SCHEDULER_UNIT_MACROS_SVH
`define FAIR_SHARE_TASK_SCHEDULER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FSTS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");
`define FSTS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: label");
`else
`define FSTS_ASSERT_IMPL(label, clk, rst_n, prop)
`define FSTS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/core/fsts_pkg.sv */
package fsts_pkg;

    localparam int MaxTasks = 16;
    localparam int FracBits = 16;
    localparam int TimeBits = 24;
    localparam int SlotBits = $clog2(MaxTasks);
    localparam int CntBits = $clog2(MaxTasks + 1);
    localparam int VrtBits = 40;
    localparam int NumBits = 16 + FracBits;
    localparam int DivCntBits = $clog2(NumBits + 1);
    localparam logic [TimeBits-1:0] TimeMax = '1;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] burst_time;
        logic [15:0] arrival_time;
        logic        last_task;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  task_id_res;
        logic [23:0] start_time;
        logic [23:0] end_time;
        logic [23:0] waiting_time;
        logic        last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    // Candidate carried along the cell chain during a scan.
    typedef struct packed {
        logic                found;
        logic [SlotBits-1:0] slot;
        logic [VrtBits-1:0]  vrt;
        logic                pend;
        logic [15:0]         next_arr;
    } cand_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [VrtBits-1:0] vrt;
        logic        active;
    } slot_view_t;

endpackage

/* rtl/core/fsts_cell.sv */
module fsts_cell
    import fsts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SlotBits-1:0] slot_id,
    input  slot_view_t          view,
    input  logic [TimeBits-1:0] now,
    input  cand_t               cand_in,
    output cand_t               cand_out
);

    cand_t cand_next;
    cand_t cand_reg;
    logic  ready;
    logic  waiting;

    always_comb
    begin
        ready = view.active && (view.remaining != 16'd0)
            && ({{(TimeBits-16){1'b0}}, view.arrival} <= now);
        waiting = view.active && (view.remaining != 16'd0) && !ready;
        cand_next = cand_in;
        if (ready && (!cand_in.found || view.vrt < cand_in.vrt))
        begin
            cand_next.found = 1'b1;
            cand_next.slot = slot_id;
            cand_next.vrt = view.vrt;
        end
        if (waiting && (!cand_in.pend || view.arrival < cand_in.next_arr))
        begin
            cand_next.pend = 1'b1;
            cand_next.next_arr = view.arrival;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cand_reg <= '0;
        else
            cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

/* rtl/core/fsts_div.sv */
module fsts_div
    import fsts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NumBits-1:0] numer,
    input  logic [15:0]        denom,
    output logic               done,
    output logic [NumBits-1:0] quot
);

    logic [NumBits-1:0]    q_reg, q_next;
    logic [16:0]           r_reg, r_next;
    logic [DivCntBits-1:0] n_reg, n_next;
    logic                  busy_reg, busy_next;
    logic [16:0]           trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[15:0], q_reg[NumBits-1]};
        if (start)
        begin
            q_next = numer;
            r_next = '0;
            n_next = DivCntBits'(NumBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, denom})
            begin
                r_next = trial - {1'b0, denom};
                q_next = {q_reg[NumBits-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NumBits-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == DivCntBits'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done = !busy_reg && !start;
    assign quot = q_reg;

endmodule

/* rtl/core/fair_share_task_scheduler_unit.sv */
// Task records are accepted one per cycle while loading; a record without the
// last mark does not start a run. After the last record the block schedules on
// its own: a round that runs a task scans the cell chain, decides, divides and
// updates; an idle round scans, decides and jumps to the next arrival. Reports
// then follow one per cycle, stall permitting, and the input stalls until the last
// one is issued. rst_n is asynchronous, active low: empty table, quantum of one.
`include "fair_share_task_scheduler_unit_macros.svh"

module fair_share_task_scheduler_unit
    import fsts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    // Task table. The scan chain reads every slot at a fixed place, so these
    // stay as flip-flop rows; only the active and started bits need reset.
    logic [7:0]          id_reg     [MaxTasks];
    logic [15:0]         burst_reg  [MaxTasks];
    logic [15:0]         arr_reg    [MaxTasks];
    logic [15:0]         rem_reg    [MaxTasks];
    logic [VrtBits-1:0]  vrt_reg    [MaxTasks];
    logic [TimeBits-1:0] st_reg     [MaxTasks];
    logic [TimeBits-1:0] end_reg    [MaxTasks];
    logic [MaxTasks-1:0] started_reg;

    logic [15:0]         quantum_reg;
    logic [CntBits-1:0]  loaded_reg, loaded_next;
    logic [CntBits-1:0]  done_cnt_reg, done_cnt_next;
    logic [TimeBits-1:0] now_reg, now_next;
    logic [SlotBits:0]   scan_reg, scan_next;
    logic [SlotBits-1:0] rpt_reg, rpt_next;
    logic [SlotBits-1:0] pick_reg, pick_next;
    logic [15:0]         run_reg, run_next;
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic                accept_in;
    logic                store_rec;
    logic                div_start;
    logic                div_done;
    logic [NumBits-1:0]  div_q;
    logic [15:0]         in_burst;
    logic [15:0]         q_eff;
    logic [TimeBits:0]   time_sum;

    slot_view_t          views [MaxTasks];
    cand_t               chain [MaxTasks+1];

    assign in_burst = (in_data.burst_time == 16'd0) ? 16'd1 : in_data.burst_time;
    assign q_eff = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign accept_in = in_valid && !in_stall;
    assign store_rec = accept_in && (loaded_reg < CntBits'(MaxTasks));
    assign in_stall = (state_reg != ST_LOAD);

    // Chain of cells: each cell compares its slot against the candidate handed
    // from its neighbor and registers the better one. The head sees no task.
    assign chain[0] = '0;
    genvar g;
    generate
        for (g = 0; g < MaxTasks; g++)
        begin : g_cell
            assign views[g].arrival = arr_reg[g];
            assign views[g].remaining = rem_reg[g];
            assign views[g].vrt = vrt_reg[g];
            assign views[g].active = (CntBits'(g) < loaded_reg);
            fsts_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .slot_id  (SlotBits'(g)),
                .view     (views[g]),
                .now      (now_reg),
                .cand_in  (chain[g]),
                .cand_out (chain[g+1])
            );
        end
    endgenerate

    // The divide is started in the decide cycle, so it takes the slice length
    // that is being chosen in that same cycle.
    fsts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer ({run_next, {FracBits{1'b0}}}),
        .denom (burst_reg[pick_reg]),
        .done  (div_done),
        .quot  (div_q)
    );

    assign time_sum = {1'b0, now_reg} + {{(TimeBits-15){1'b0}}, run_reg};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (accept_in && in_data.last_task)
                    state_next = (done_cnt_reg < loaded_next) ? ST_SCAN : ST_REPORT;
            ST_SCAN:
                if (scan_reg == (SlotBits+1)'(MaxTasks))
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = chain[MaxTasks].found ? ST_DIV : ST_SCAN;
            ST_DIV:
                if (div_done)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                if (done_cnt_next == loaded_reg)
                    state_next = ST_REPORT;
                else
                    state_next = ST_SCAN;
            ST_REPORT:
                if ((!out_valid_reg || !out_stall)
                    && (CntBits'(rpt_reg) + 1'b1 == loaded_reg))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        loaded_next = loaded_reg;
        done_cnt_next = done_cnt_reg;
        now_next = now_reg;
        scan_next = scan_reg;
        rpt_next = rpt_reg;
        pick_next = pick_reg;
        run_next = run_reg;
        div_start = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        if (store_rec)
            loaded_next = loaded_reg + 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                scan_next = '0;
                rpt_next = '0;
            end
            ST_SCAN:
                scan_next = scan_reg + 1'b1;
            ST_DECIDE:
            begin
                scan_next = '0;
                if (chain[MaxTasks].found)
                begin
                    pick_next = chain[MaxTasks].slot;
                    run_next = (rem_reg[chain[MaxTasks].slot] > q_eff)
                        ? q_eff : rem_reg[chain[MaxTasks].slot];
                    div_start = 1'b1;
                end
                else
                    now_next = {{(TimeBits-16){1'b0}}, chain[MaxTasks].next_arr};
            end
            ST_DIV:
                ;
            ST_UPDATE:
            begin
                now_next = time_sum[TimeBits] ? TimeMax : time_sum[TimeBits-1:0];
                if (rem_reg[pick_reg] == run_reg)
                    done_cnt_next = done_cnt_reg + 1'b1;
            end
            ST_REPORT:
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.task_id_res = id_reg[rpt_reg];
                    out_next.start_time = st_reg[rpt_reg];
                    out_next.end_time = end_reg[rpt_reg];
                    if (end_reg[rpt_reg] > ({{(TimeBits-16){1'b0}}, arr_reg[rpt_reg]}
                        + {{(TimeBits-16){1'b0}}, burst_reg[rpt_reg]}))
                        out_next.waiting_time = end_reg[rpt_reg]
                            - {{(TimeBits-16){1'b0}}, arr_reg[rpt_reg]}
                            - {{(TimeBits-16){1'b0}}, burst_reg[rpt_reg]};
                    else
                        out_next.waiting_time = '0;
                    out_next.last_result = (CntBits'(rpt_reg) + 1'b1 == loaded_reg);
                    rpt_next = rpt_reg + 1'b1;
                    if (CntBits'(rpt_reg) + 1'b1 == loaded_reg)
                    begin
                        loaded_next = '0;
                        done_cnt_next = '0;
                        now_next = '0;
                    end
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            quantum_reg <= 16'd1;
            loaded_reg <= '0;
            done_cnt_reg <= '0;
            now_reg <= '0;
            scan_reg <= '0;
            rpt_reg <= '0;
            pick_reg <= '0;
            run_reg <= '0;
            out_valid_reg <= 1'b0;
            started_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                quantum_reg <= cfg_wdata;
            loaded_reg <= loaded_next;
            done_cnt_reg <= done_cnt_next;
            now_reg <= now_next;
            scan_reg <= scan_next;
            rpt_reg <= rpt_next;
            pick_reg <= pick_next;
            run_reg <= run_next;
            out_valid_reg <= out_valid_next;
            if (store_rec)
                started_reg[loaded_reg[SlotBits-1:0]] <= 1'b0;
            if (state_reg == ST_DECIDE && chain[MaxTasks].found)
                started_reg[chain[MaxTasks].slot] <= 1'b1;
        end
    end

    // Payload rows; no reset needed.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (store_rec)
        begin
            id_reg[loaded_reg[SlotBits-1:0]] <= in_data.task_id;
            burst_reg[loaded_reg[SlotBits-1:0]] <= in_burst;
            rem_reg[loaded_reg[SlotBits-1:0]] <= in_burst;
            arr_reg[loaded_reg[SlotBits-1:0]] <= in_data.arrival_time;
            vrt_reg[loaded_reg[SlotBits-1:0]] <= '0;
        end
        if (state_reg == ST_DECIDE && chain[MaxTasks].found
            && !started_reg[chain[MaxTasks].slot])
            st_reg[chain[MaxTasks].slot] <= now_reg;
        if (state_reg == ST_UPDATE)
        begin
            rem_reg[pick_reg] <= rem_reg[pick_reg] - run_reg;
            vrt_reg[pick_reg] <= vrt_reg[pick_reg] + VrtBits'(div_q);
            if (rem_reg[pick_reg] == run_reg)
                end_reg[pick_reg] <= now_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `FSTS_ASSERT_NEVER(a_in_only_loading, clk, rst_n, accept_in && state_reg != ST_LOAD)
    `FSTS_ASSERT_NEVER(a_done_le_loaded, clk, rst_n, done_cnt_reg > loaded_reg)
    `FSTS_ASSERT_IMPL(a_update_after_div, clk, rst_n,
        (state_reg == ST_UPDATE) |-> $past(state_reg == ST_DIV))
    `FSTS_ASSERT_NEVER(a_pick_live, clk, rst_n,
        state_reg == ST_UPDATE && run_reg > rem_reg[pick_reg])

endmodule

/* tb/testbench.sv */
module testbench
    import fsts_pkg::*;
();

    // The run is bounded by this many clock cycles; normal runs take far fewer.
    localparam int unsigned CycleLimit = 20000000;
    // The number of cycles allowed for the scheduler to settle after its last report.
    localparam int SettleCycles = 200;
    localparam int RandomItems = 250;
    localparam int NoWrite = -1;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [15:0] cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    fair_share_task_scheduler_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // One row of the directed table. A row may first write the quantum, and a
    // row that closes a single-task batch may carry its report typed in.
    typedef struct {
        int        quantum_write;
        in_item_t  rec;
        bit        typed;
        out_item_t report;
    } directed_row_t;

    directed_row_t directed_rows[$];
    out_item_t     pending_reports[$];
    out_item_t     batch_reports[$];

    // The predictor's copy of the batch being loaded and of the quantum.
    logic [7:0]  batch_ids[MaxTasks];
    logic [15:0] batch_bursts[MaxTasks];
    logic [15:0] batch_arrivals[MaxTasks];
    int          batch_count;
    logic [15:0] quantum;

    int          error_count;
    int unsigned cycle_count;
    bit          hold_output;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Run the fair-share scheduler over the stored batch and return its
    // reports in load order. Idle stretches jump to the next arrival.
    task automatic schedule_batch();
        longint unsigned now;
        longint unsigned vruntime[MaxTasks];
        longint unsigned remaining[MaxTasks];
        longint unsigned started_at[MaxTasks];
        longint unsigned ended_at[MaxTasks];
        longint unsigned next_arrival;
        longint unsigned slice;
        longint unsigned need;
        longint unsigned q;
        bit              started[MaxTasks];
        int              finished;
        int              pick;
        out_item_t       rep;
        now = 0;
        finished = 0;
        q = (quantum == 16'd0) ? 1 : quantum;
        for (int i = 0; i < batch_count; i++)
        begin
            vruntime[i] = 0;
            remaining[i] = batch_bursts[i];
            started[i] = 1'b0;
        end
        while (finished < batch_count)
        begin
            pick = -1;
            next_arrival = '1;
            for (int i = 0; i < batch_count; i++)
            begin
                if (remaining[i] != 0)
                begin
                    if (batch_arrivals[i] <= now)
                    begin
                        if (pick < 0 || vruntime[i] < vruntime[pick])
                            pick = i;
                    end
                    else if (batch_arrivals[i] < next_arrival)
                        next_arrival = batch_arrivals[i];
                end
            end
            if (pick < 0)
                now = next_arrival;
            else
            begin
                if (!started[pick])
                begin
                    started[pick] = 1'b1;
                    started_at[pick] = now;
                end
                slice = (remaining[pick] > q) ? q : remaining[pick];
                now += slice;
                remaining[pick] -= slice;
                vruntime[pick] += (slice << FracBits) / batch_bursts[pick];
                if (remaining[pick] == 0)
                begin
                    ended_at[pick] = now;
                    finished++;
                end
            end
        end
        batch_reports.delete();
        for (int i = 0; i < batch_count; i++)
        begin
            need = batch_arrivals[i] + batch_bursts[i];
            rep.task_id_res  = batch_ids[i];
            rep.start_time   = started_at[i][23:0];
            rep.end_time     = ended_at[i][23:0];
            rep.waiting_time = (ended_at[i] > need) ? 24'(ended_at[i] - need) : 24'd0;
            rep.last_result  = (i == batch_count - 1);
            batch_reports.push_back(rep);
        end
        batch_count = 0;
    endtask

    // Record an accepted task record. Records past a full table are dropped,
    // but the last mark still starts the schedule.
    task automatic take_record(input in_item_t rec, input bit typed, input out_item_t report);
        if (batch_count < MaxTasks)
        begin
            batch_ids[batch_count] = rec.task_id;
            batch_bursts[batch_count] = (rec.burst_time == 16'd0) ? 16'd1 : rec.burst_time;
            batch_arrivals[batch_count] = rec.arrival_time;
            batch_count++;
        end
        if (rec.last_task)
        begin
            schedule_batch();
            if (typed)
                pending_reports.push_back(report);
            else
                foreach (batch_reports[i])
                    pending_reports.push_back(batch_reports[i]);
        end
    endtask

    // Offer one record after a random gap and hold it until the transaction completes.
    task automatic send_record(input in_item_t rec, input bit typed, input out_item_t report);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rec;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        take_record(rec, typed, report);
    endtask

    // The quantum is written only once the block has drained every report.
    task automatic write_quantum(input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        quantum = value;
    endtask

    task automatic add_row(input int qw, input logic [7:0] id, input logic [15:0] burst,
                           input logic [15:0] arrival, input bit last_rec, input bit typed,
                           input logic [23:0] start_t, input logic [23:0] end_t);
        directed_row_t row;
        row.quantum_write = qw;
        row.rec = '{task_id: id, burst_time: burst, arrival_time: arrival, last_task: last_rec};
        row.typed = typed;
        row.report = '{task_id_res: id, start_time: start_t, end_time: end_t,
                       waiting_time: 24'd0, last_result: 1'b1};
        directed_rows.push_back(row);
    endtask

    // Stimulus: the directed table first, then random batches.
    initial
    begin
        int          items;
        int          batch_len;
        logic [15:0] q_next;
        in_item_t    rec;
        out_item_t   no_report;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        quantum     = 16'd1;
        batch_count = 0;
        no_report   = '0;
        hold_output = 1'b0;

        // A single task with the smallest burst under the reset quantum.
        add_row(NoWrite, 8'h00, 16'd1, 16'd0, 1'b1, 1'b1, 24'd0, 24'd1);
        // The largest burst and identifier, finished in one slice of the largest quantum.
        add_row(65535, 8'hFF, 16'hFFFF, 16'd0, 1'b1, 1'b1, 24'd0, 24'd65535);
        // Zero quantum and zero burst both act as one; the task arrives at the latest tick.
        add_row(0, 8'h03, 16'd0, 16'hFFFF, 1'b1, 1'b1, 24'd65535, 24'd65536);
        // A small batch with staggered arrivals that share the processor.
        add_row(2, 8'h01, 16'd5, 16'd0, 1'b0, 1'b0, '0, '0);
        add_row(NoWrite, 8'h02, 16'd3, 16'd1, 1'b0, 1'b0, '0, '0);
        add_row(NoWrite, 8'h03, 16'd4, 16'd2, 1'b0, 1'b0, '0, '0);
        add_row(NoWrite, 8'h04, 16'd1, 16'd3, 1'b1, 1'b0, '0, '0);
        // A full table; the seventeenth record is dropped but its last mark starts the run.
        for (int i = 0; i < MaxTasks + 1; i++)
            add_row((i == 0) ? 7 : NoWrite, 8'(16 + i), 16'(i % 5 + 1), 16'(i),
                    (i == MaxTasks), 1'b0, '0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].quantum_write != NoWrite)
                write_quantum(16'(directed_rows[i].quantum_write));
            send_record(directed_rows[i].rec, directed_rows[i].typed, directed_rows[i].report);
        end

        // The long output hold meets the reports of the full table while the first
        // random batch is already offered, so the block backs up and stalls its input.
        // That batch keeps the current quantum, as the block is still busy.
        hold_output = 1'b1;
        items = 0;
        while (items < RandomItems)
        begin
            case ($urandom_range(0, 5))
                0: q_next = 16'd0;
                1: q_next = 16'hFFFF;
                2: q_next = 16'($urandom_range(4096, 65535));
                default: q_next = 16'($urandom_range(1, 6));
            endcase
            if (items > 0)
                write_quantum(q_next);
            else
                q_next = quantum;
            batch_len = $urandom_range(1, MaxTasks + 2);
            for (int k = 0; k < batch_len; k++)
            begin
                rec.task_id = 8'($urandom_range(0, 255));
                // Large bursts only meet large quanta so each batch stays short.
                rec.burst_time = (q_next >= 16'd4096) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 12));
                rec.arrival_time = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                               : 16'($urandom_range(0, 40));
                rec.last_task = (k == batch_len - 1);
                send_record(rec, 1'b0, no_report);
                items++;
            end
        end
        in_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (error_count == 0)
            $display("fair_share_task_scheduler_unit verification clean");
        else
            $display("fair_share_task_scheduler_unit verification failed");
        $finish;
    end

    // The receiver stalls a random number of cycles before each transaction,
    // and once for a long stretch while the sender keeps loading.
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_output = 1'b0;
            end
            hold = $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    // Every report is checked field by field against the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report for task %0d", out_data.task_id_res);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (out_data.task_id_res !== want.task_id_res)
                begin
                    $error("task_id_res: expected %0d, got %0d",
                           want.task_id_res, out_data.task_id_res);
                    error_count++;
                end
                if (out_data.start_time !== want.start_time)
                begin
                    $error("start_time: expected %0d, got %0d",
                           want.start_time, out_data.start_time);
                    error_count++;
                end
                if (out_data.end_time !== want.end_time)
                begin
                    $error("end_time: expected %0d, got %0d", want.end_time, out_data.end_time);
                    error_count++;
                end
                if (out_data.waiting_time !== want.waiting_time)
                begin
                    $error("waiting_time: expected %0d, got %0d",
                           want.waiting_time, out_data.waiting_time);
                    error_count++;
                end
                if (out_data.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, out_data.last_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        error_count = 0;
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("fair_share_task_scheduler_unit verification failed");
            $finish;
        end
    end

endmodule

/* fair_share_task_scheduler_unit.f */
+incdir+rtl/core
rtl/core/fsts_pkg.sv
rtl/core/fsts_cell.sv
rtl/core/fsts_div.sv
rtl/core/fair_share_task_scheduler_unit.sv
tb/testbench.sv
